// ----- rtl/distance_evicting_page_cache_assert.svh -----
// assertion macros shared by the checker
`ifndef DISTANCE_EVICTING_PAGE_CACHE_ASSERT_SVH
`define DISTANCE_EVICTING_PAGE_CACHE_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define DEPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds in this cycle, consequent in the next one
`define DEPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/depc_pkg.sv -----
`default_nettype none
package depc_pkg;

  localparam logic [6:0] CAP_RESET = 7'd32;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_OFFER  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] page;
    logic [31:0] stamp;
    logic [31:0] center;
    logic [31:0] bound_low;
    logic [31:0] bound_high;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        evict_valid;
    logic [31:0] evict_page;
    logic        evict_side;
    logic        overflow;
  } out_t;

endpackage
`default_nettype wire

// ----- rtl/distance_evicting_page_cache.sv -----
// path to out_valid: scan, accept, insert, then evict, but a lookup hit,
// a rejected offer or an overflow goes from insert straight to finish
// in_stall holds off a new transaction until the last result is loaded; the single read port
// scans the entry memory, one slot per cycle, followed by decide, write and evict steps
// reset: synchronous, clears valid bits, count, saved center and bounds, capacity to 32
// entry memory needs no clearing pass, valid flops mask stale words
`default_nettype none
module distance_evicting_page_cache #(
  parameter int SLOTS     = 64,
  parameter int PAGE_BITS = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  depc_pkg::in_t     in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output depc_pkg::out_t    out_data,
  input  wire               cfg_wr_en,
  input  wire  [6:0]        cfg_wr_data
);
  import depc_pkg::*;

  localparam int PW = (PAGE_BITS < 32) ? PAGE_BITS : 32;
  localparam int DW = PW + 1;
  localparam int EW = PW + 32;
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MW = (CW > 7) ? CW : 7;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_ACCEPT = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_EVICT  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]       state_r;
  logic [AW-1:0]    idx_r;
  logic [SLOTS-1:0] valid_r;
  logic [CW-1:0]    count_r;
  logic [6:0]       cap_r;
  logic [PW-1:0]    center_r, bnd_lo_r, bnd_hi_r;

  logic [EW-1:0]    mem_r [SLOTS];
  logic [EW-1:0]    rd_data_r;

  logic             op_r;
  logic [PW-1:0]    page_r;
  logic [31:0]      stamp_r;

  logic             any_r, match_r, free_r, accept_r;
  logic [AW-1:0]    lo_idx_r, hi_idx_r, match_idx_r, free_idx_r;
  logic [PW-1:0]    lo_page_r, hi_page_r;
  logic [31:0]      oldest_r;

  logic             hit_r, ev_r, ev_side_r, ovf_r;
  logic [PW-1:0]    ev_page_r;

  logic             out_valid_r;
  out_t             out_data_r;

  logic             in_acc, rd_en, mem_we, out_load;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [PW-1:0]    e_page;
  logic [31:0]      e_stamp;
  logic             e_valid;
  logic [DW-1:0]    dl, dh, dfar, far_abs, mine, mine_abs;
  logic             evict_go, take_lo, take_hi;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign e_page  = rd_data_r[EW-1:32];
  assign e_stamp = rd_data_r[31:0];
  assign e_valid = valid_r[idx_r];

  // scan runs one slot ahead of the registered read data
  assign rd_addr = (state_r == S_IDLE) ? '0 : idx_r + AW'(1);
  assign rd_en   = (state_r == S_IDLE) || (state_r == S_SCAN && idx_r != LAST);
  assign wr_addr = match_r ? match_idx_r : free_idx_r;
  assign mem_we  = (state_r == S_INSERT) && accept_r && (match_r || free_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= {page_r, stamp_r};
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // offer distance check against the farther end of the stored span
  always_comb begin
    dl       = {1'b0, center_r} - {1'b0, lo_page_r};
    dh       = {1'b0, hi_page_r} - {1'b0, center_r};
    dfar     = (dl > dh) ? dl : dh;
    far_abs  = dfar[DW-1] ? DW'(0) - dfar : dfar;
    mine     = {1'b0, page_r} - {1'b0, center_r};
    mine_abs = mine[DW-1] ? DW'(0) - mine : mine;
  end

  assign evict_go = (MW'(count_r) > MW'(cap_r)) &&
                    ((bnd_lo_r < lo_page_r) || (hi_page_r < bnd_hi_r));
  assign take_lo  = dl > dh;
  assign take_hi  = !take_lo && (hi_page_r > center_r);
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      center_r    <= '0;
      bnd_lo_r    <= '0;
      bnd_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            idx_r   <= '0;
            state_r <= S_SCAN;
            if (in_data.op == OP_LOOKUP) begin
              center_r <= in_data.center[PW-1:0];
              bnd_lo_r <= in_data.bound_low[PW-1:0];
              bnd_hi_r <= in_data.bound_high[PW-1:0];
            end
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + AW'(1);
          if (idx_r == LAST) begin
            state_r <= S_ACCEPT;
          end
        end
        S_ACCEPT: begin
          state_r <= S_INSERT;
        end
        S_INSERT: begin
          if (!accept_r) begin
            state_r <= S_FINISH;
          end else if (match_r) begin
            state_r <= (op_r == OP_LOOKUP) ? S_FINISH : S_EVICT;
          end else if (free_r) begin
            valid_r[free_idx_r] <= 1'b1;
            count_r             <= count_r + CW'(1);
            state_r             <= S_EVICT;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_EVICT: begin
          if (evict_go && (take_lo || take_hi)) begin
            valid_r[take_lo ? lo_idx_r : hi_idx_r] <= 1'b0;
            count_r                                <= count_r - CW'(1);
          end
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers of the item under work
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r      <= in_data.op;
          page_r    <= in_data.page[PW-1:0];
          stamp_r   <= in_data.stamp;
          any_r     <= 1'b0;
          match_r   <= 1'b0;
          free_r    <= 1'b0;
          hit_r     <= 1'b0;
          ev_r      <= 1'b0;
          ev_side_r <= 1'b0;
          ev_page_r <= '0;
          ovf_r     <= 1'b0;
        end
      end
      S_SCAN: begin
        if (e_valid) begin
          if (!any_r) begin
            any_r     <= 1'b1;
            lo_idx_r  <= idx_r;
            hi_idx_r  <= idx_r;
            lo_page_r <= e_page;
            hi_page_r <= e_page;
            oldest_r  <= e_stamp;
          end else begin
            if (e_page < lo_page_r) begin
              lo_idx_r  <= idx_r;
              lo_page_r <= e_page;
            end
            if (e_page > hi_page_r) begin
              hi_idx_r  <= idx_r;
              hi_page_r <= e_page;
            end
            if (e_stamp < oldest_r) begin
              oldest_r <= e_stamp;
            end
          end
          if (e_page == page_r) begin
            match_r     <= 1'b1;
            match_idx_r <= idx_r;
          end
        end else if (!free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= idx_r;
        end
      end
      S_ACCEPT: begin
        accept_r <= (op_r == OP_LOOKUP) || !any_r || (stamp_r < oldest_r) ||
                    (far_abs > mine_abs);
      end
      S_INSERT: begin
        if (accept_r) begin
          if (match_r) begin
            hit_r <= 1'b1;
          end else if (free_r) begin
            hit_r <= (op_r == OP_OFFER);
            any_r <= 1'b1;
            // the new page may widen the stored span
            if (!any_r || page_r < lo_page_r) begin
              lo_idx_r  <= free_idx_r;
              lo_page_r <= page_r;
            end
            if (!any_r || page_r > hi_page_r) begin
              hi_idx_r  <= free_idx_r;
              hi_page_r <= page_r;
            end
          end else begin
            ovf_r <= 1'b1;
          end
        end
      end
      S_EVICT: begin
        if (evict_go && (take_lo || take_hi)) begin
          ev_r      <= 1'b1;
          ev_side_r <= take_hi;
          ev_page_r <= take_lo ? lo_page_r : hi_page_r;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          out_data_r.hit         <= hit_r;
          out_data_r.evict_valid <= ev_r;
          out_data_r.evict_page  <= 32'(ev_page_r);
          out_data_r.evict_side  <= ev_side_r;
          out_data_r.overflow    <= ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/depc_checker.sv -----
`default_nettype none
`include "distance_evicting_page_cache_assert.svh"
module depc_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_stall,
  input wire            out_valid,
  input wire            out_stall,
  input depc_pkg::out_t out_data
);
  import depc_pkg::*;

  `DEPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  `DEPC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "took a second transaction while busy")
  `DEPC_ASSERT_NOW(a_no_evict_zero, out_valid && !out_data.evict_valid, out_data.evict_page == 32'd0 && !out_data.evict_side, "eviction fields set without eviction")
  `DEPC_ASSERT_NOW(a_overflow_alone, out_valid && out_data.overflow, !out_data.hit && !out_data.evict_valid, "overflow together with hit or eviction")

endmodule

bind distance_evicting_page_cache depc_checker u_depc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_data    (out_data)
);
`default_nettype wire
